/* rtl/assert_macros.svh */
// ----------------------------------------------------------------------------
// Assertion macros
// Clocked assertion helpers, compiled out when SYNTH is defined.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTH
`define AST_CLK(lbl, clk, rst_n, prop) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error("assertion failed");
`define AST_NEVER(lbl, clk, rst_n, cond) `AST_CLK(lbl, clk, rst_n, !(cond))
`else
`define AST_CLK(lbl, clk, rst_n, prop)
`define AST_NEVER(lbl, clk, rst_n, cond)
`endif
`endif

/* rtl/cidr_pkg.sv */
// ----------------------------------------------------------------------------
// cidr_pkg
// Shared types and constants of the clause id remapper.
// ----------------------------------------------------------------------------
package cidr_pkg;

    localparam int TABLE_ENTRIES = 1024;
    localparam int TBL_AW        = $clog2(TABLE_ENTRIES);
    localparam int CNT_W         = TBL_AW + 1;
    localparam int CFG_W         = 11;
    localparam int REM_W         = 10;
    localparam int ID_W          = 64;

    localparam logic [1:0] FN_HINT   = 2'd0;
    localparam logic [1:0] FN_ASSIGN = 2'd1;
    localparam logic [1:0] FN_DELETE = 2'd2;
    localparam logic [1:0] FN_NOP    = 2'd3;

    localparam logic [1:0] CFG_SOLVER_COUNT = 2'd0;
    localparam logic [1:0] CFG_SOLVER_REM   = 2'd1;

    typedef struct packed {
        logic [1:0]      func;
        logic [ID_W-1:0] clause_id;
    } t_req;

    typedef struct packed {
        logic [ID_W-1:0] mapped_id;
        logic            entry_found;
        logic            table_full;
    } t_rsp;

    typedef struct packed {
        logic            valid;
        logic [ID_W-1:0] key;
        logic [ID_W-1:0] offset;
    } t_entry;

endpackage

/* rtl/cidr_table.sv */
// ----------------------------------------------------------------------------
// cidr_table
// Offset table memory: one write port, one read port, registered read data.
// ----------------------------------------------------------------------------
module cidr_table (
    input  logic                         i_clk,
    input  logic                         i_rd_en,
    input  logic [cidr_pkg::TBL_AW-1:0]  i_rd_addr,
    output cidr_pkg::t_entry             o_rd_data,
    input  logic                         i_wr_en,
    input  logic [cidr_pkg::TBL_AW-1:0]  i_wr_addr,
    input  cidr_pkg::t_entry             i_wr_data
);

    cidr_pkg::t_entry r_mem [cidr_pkg::TABLE_ENTRIES];

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        if (i_rd_en) begin
            o_rd_data <= r_mem[i_rd_addr];
        end
    end

endmodule

/* rtl/cidr_mod.sv */
// ----------------------------------------------------------------------------
// cidr_mod
// Bit-serial remainder of a 64-bit value by an 11-bit divisor, one bit a cycle.
// ----------------------------------------------------------------------------
module cidr_mod (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_start,
    input  logic [cidr_pkg::ID_W-1:0]    i_dividend,
    input  logic [cidr_pkg::CFG_W-1:0]   i_divisor,
    output logic                         o_done,
    output logic [cidr_pkg::CFG_W-1:0]   o_rem
);

    localparam int STEP_W = $clog2(cidr_pkg::ID_W) + 1;

    logic                        r_busy;
    logic [STEP_W-1:0]           r_step;
    logic [cidr_pkg::ID_W-1:0]   r_shift;
    logic [cidr_pkg::CFG_W-1:0]  r_div;
    logic [cidr_pkg::CFG_W:0]    w_trial;
    logic [cidr_pkg::CFG_W:0]    w_next;

    assign w_trial = {o_rem, r_shift[cidr_pkg::ID_W-1]};
    assign w_next  = (w_trial >= {1'b0, r_div}) ? w_trial - {1'b0, r_div} : w_trial;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            o_done <= 1'b0;
            r_step <= '0;
        end else begin
            o_done <= 1'b0;
            if (i_start) begin
                r_busy  <= 1'b1;
                r_step  <= '0;
                r_shift <= i_dividend;
                r_div   <= i_divisor;
                o_rem   <= '0;
            end else if (r_busy) begin
                o_rem   <= w_next[cidr_pkg::CFG_W-1:0];
                r_shift <= {r_shift[cidr_pkg::ID_W-2:0], 1'b0};
                r_step  <= r_step + 1'b1;
                if (r_step == STEP_W'(cidr_pkg::ID_W - 1)) begin
                    r_busy <= 1'b0;
                    o_done <= 1'b1;
                end
            end
        end
    end

endmodule

/* rtl/clause_id_offset_remapper.sv */
// ----------------------------------------------------------------------------
// clause_id_offset_remapper
// Renumbers clause ids through an id-to-offset table kept in one memory.
// ----------------------------------------------------------------------------
// channel   | ports                              | handshake
// request   | i_req (func, clause_id)            | start & !busy
// result    | o_rsp (mapped_id, found, full)     | o_strobe, one cycle
// config    | i_cfg_we, i_cfg_idx, i_cfg_wdata   | i_cfg_we
//
// Every lookup scans the table memory one entry a cycle and stops at a match;
// an assign goes on to compute the local offset, and an assign that grows
// the offset also runs a 64-step serial remainder. Function code three is
// answered from idle without a scan. After reset a clearing pass over every
// table entry holds busy high.
// The receiver cannot stall; each result shows for exactly one cycle.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module clause_id_offset_remapper (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          start,
    output logic                          busy,
    input  cidr_pkg::t_req                i_req,
    output logic                          o_strobe,
    output cidr_pkg::t_rsp                o_rsp,
    input  logic                          i_cfg_we,
    input  logic [1:0]                    i_cfg_idx,
    input  logic [cidr_pkg::CFG_W-1:0]    i_cfg_wdata
);

    typedef enum logic [3:0] {
        S_CLEAR, S_IDLE, S_SCAN, S_EVAL, S_FIN, S_LOCAL, S_MAP, S_CMP,
        S_MOD, S_ROUND, S_SETOFF, S_WRITE
    } t_state;

    localparam logic [cidr_pkg::CNT_W-1:0] CNT_END = cidr_pkg::CNT_W'(cidr_pkg::TABLE_ENTRIES);
    localparam logic [cidr_pkg::CNT_W-1:0] CNT_LAST =
        cidr_pkg::CNT_W'(cidr_pkg::TABLE_ENTRIES - 1);
    localparam logic [1:0] CFG_SOLVER_COUNT_IDX = cidr_pkg::CFG_SOLVER_COUNT;
    localparam logic [1:0] CFG_SOLVER_REM_IDX   = cidr_pkg::CFG_SOLVER_REM;

    t_state                          r_state;
    logic [cidr_pkg::CFG_W-1:0]      r_nsolv;
    logic [cidr_pkg::REM_W-1:0]      r_srem;
    logic [cidr_pkg::ID_W-1:0]       r_ofs;
    logic [cidr_pkg::ID_W-1:0]       r_max;
    logic [1:0]                      r_func;
    logic [cidr_pkg::ID_W-1:0]       r_id;
    logic [cidr_pkg::CNT_W-1:0]      r_cnt;
    logic                            r_pend;
    logic [cidr_pkg::TBL_AW-1:0]     r_chk;
    logic                            r_hit;
    logic [cidr_pkg::TBL_AW-1:0]     r_slot;
    logic [cidr_pkg::ID_W-1:0]       r_off;
    logic                            r_free_ok;
    logic [cidr_pkg::TBL_AW-1:0]     r_free;
    logic [cidr_pkg::ID_W-1:0]       r_map;
    logic [cidr_pkg::ID_W-1:0]       r_local;
    logic [cidr_pkg::ID_W-1:0]       r_grown;

    cidr_pkg::t_entry                w_rd;
    logic                            w_rd_en;
    logic                            w_wr_en;
    logic [cidr_pkg::TBL_AW-1:0]     w_wr_addr;
    cidr_pkg::t_entry                w_wr_data;
    logic                            w_match;
    logic                            w_accept;
    logic [cidr_pkg::CFG_W-1:0]      w_n;
    logic [cidr_pkg::ID_W-1:0]       w_grown0;
    logic                            w_mod_start;
    logic                            w_mod_done;
    logic [cidr_pkg::CFG_W-1:0]      w_mod_rem;
    logic [cidr_pkg::CFG_W-1:0]      w_adj;

    assign busy     = (r_state != S_IDLE);
    assign w_accept = start && !busy;
    assign w_match  = r_pend && w_rd.valid && (w_rd.key == r_id);
    assign w_n      = (r_nsolv == '0) ? cidr_pkg::CFG_W'(1) : r_nsolv;
    assign w_grown0 = cidr_pkg::ID_W'(1) + r_max - r_id;
    assign w_adj    = (w_mod_rem == '0) ? '0 : w_n - w_mod_rem;
    assign w_rd_en  = (r_state == S_SCAN) && (r_cnt != CNT_END);
    assign w_mod_start = (r_state == S_CMP) && (r_map <= r_max);

    always_comb begin
        w_wr_en   = 1'b0;
        w_wr_addr = r_cnt[cidr_pkg::TBL_AW-1:0];
        w_wr_data = '0;
        unique case (r_state)
            S_CLEAR: begin
                w_wr_en = 1'b1;
            end
            S_FIN: begin
                // drop the matching entry on delete
                w_wr_en   = (r_func == cidr_pkg::FN_DELETE) && r_hit;
                w_wr_addr = r_slot;
            end
            S_WRITE: begin
                w_wr_en   = r_hit || r_free_ok;
                w_wr_addr = r_hit ? r_slot : r_free;
                w_wr_data = '{valid: 1'b1, key: r_id, offset: r_local};
            end
            default: begin
                w_wr_en = 1'b0;
            end
        endcase
    end

    cidr_table u_table (
        .i_clk     (i_clk),
        .i_rd_en   (w_rd_en),
        .i_rd_addr (r_cnt[cidr_pkg::TBL_AW-1:0]),
        .o_rd_data (w_rd),
        .i_wr_en   (w_wr_en),
        .i_wr_addr (w_wr_addr),
        .i_wr_data (w_wr_data)
    );

    cidr_mod u_mod (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (w_mod_start),
        .i_dividend (w_grown0),
        .i_divisor  (w_n),
        .o_done     (w_mod_done),
        .o_rem      (w_mod_rem)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_CLEAR;
            r_cnt     <= '0;
            r_nsolv   <= cidr_pkg::CFG_W'(1);
            r_srem    <= '0;
            r_ofs     <= '0;
            r_max     <= cidr_pkg::ID_W'(1);
            r_pend    <= 1'b0;
            r_hit     <= 1'b0;
            r_free_ok <= 1'b0;
            o_strobe  <= 1'b0;
        end else begin
            o_strobe <= 1'b0;
            if (i_cfg_we) begin
                unique case (i_cfg_idx)
                    CFG_SOLVER_COUNT_IDX: r_nsolv <= i_cfg_wdata;
                    CFG_SOLVER_REM_IDX:   r_srem  <= i_cfg_wdata[cidr_pkg::REM_W-1:0];
                    default: ;
                endcase
            end
            unique case (r_state)
                S_CLEAR: begin
                    r_cnt <= r_cnt + 1'b1;
                    if (r_cnt == CNT_LAST) begin
                        r_state <= S_IDLE;
                    end
                end
                S_IDLE: begin
                    if (w_accept) begin
                        r_func    <= i_req.func;
                        r_id      <= i_req.clause_id;
                        r_cnt     <= '0;
                        r_pend    <= 1'b0;
                        r_hit     <= 1'b0;
                        r_free_ok <= 1'b0;
                        if (i_req.func == cidr_pkg::FN_NOP) begin
                            o_strobe <= 1'b1;
                            o_rsp    <= '{mapped_id: i_req.clause_id,
                                          entry_found: 1'b0, table_full: 1'b0};
                        end else begin
                            r_state <= S_SCAN;
                        end
                    end
                end
                S_SCAN: begin
                    if (w_match) begin
                        r_hit   <= 1'b1;
                        r_slot  <= r_chk;
                        r_off   <= w_rd.offset;
                        r_pend  <= 1'b0;
                        r_state <= S_EVAL;
                    end else begin
                        // remember the lowest free slot for a later insert
                        if (r_pend && !w_rd.valid && !r_free_ok) begin
                            r_free    <= r_chk;
                            r_free_ok <= 1'b1;
                        end
                        if (r_cnt != CNT_END) begin
                            r_chk  <= r_cnt[cidr_pkg::TBL_AW-1:0];
                            r_pend <= 1'b1;
                            r_cnt  <= r_cnt + 1'b1;
                        end else begin
                            r_pend <= 1'b0;
                            if (!r_pend) begin
                                r_state <= S_EVAL;
                            end
                        end
                    end
                end
                S_EVAL: begin
                    r_map   <= r_id + (r_hit ? r_off : '0);
                    r_state <= (r_func == cidr_pkg::FN_ASSIGN) ? S_LOCAL : S_FIN;
                end
                S_FIN: begin
                    if ((r_func == cidr_pkg::FN_HINT) && (r_map > r_max)) begin
                        r_max <= r_map;
                    end
                    o_strobe <= 1'b1;
                    o_rsp    <= '{mapped_id: r_map, entry_found: r_hit, table_full: 1'b0};
                    r_state  <= S_IDLE;
                end
                S_LOCAL: begin
                    r_local <= r_ofs + cidr_pkg::ID_W'(r_srem);
                    r_state <= S_MAP;
                end
                S_MAP: begin
                    r_map   <= r_id + r_local;
                    r_state <= S_CMP;
                end
                S_CMP: begin
                    if (r_map <= r_max) begin
                        r_grown <= w_grown0;
                        r_state <= S_MOD;
                    end else begin
                        r_state <= S_WRITE;
                    end
                end
                S_MOD: begin
                    if (w_mod_done) begin
                        r_grown <= r_grown + cidr_pkg::ID_W'(w_adj);
                        r_state <= S_ROUND;
                    end
                end
                S_ROUND: begin
                    r_state <= S_SETOFF;
                end
                S_SETOFF: begin
                    r_ofs   <= r_grown;
                    r_local <= r_grown + cidr_pkg::ID_W'(r_srem);
                    r_state <= S_WRITE;
                end
                S_WRITE: begin
                    r_max    <= cidr_pkg::ID_W'(1);
                    o_strobe <= 1'b1;
                    o_rsp    <= '{mapped_id: r_id + r_local, entry_found: r_hit,
                                  table_full: !(r_hit || r_free_ok)};
                    r_state  <= S_IDLE;
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    `AST_NEVER(a_full_only_assign, i_clk, i_rst_n,
        o_strobe && o_rsp.table_full && (r_func != cidr_pkg::FN_ASSIGN))
    `AST_CLK(a_accept_progress, i_clk, i_rst_n, w_accept |=> (busy || o_strobe))
    `AST_NEVER(a_mod_done_state, i_clk, i_rst_n, w_mod_done && (r_state != S_MOD))

endmodule

/* tb/sv/testbench.sv */
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for the clause id remapper: drives requests with random
// gaps and register settings, predicts every result with an id-to-offset
// table model of its own, and compares each strobed result with it.
// ----------------------------------------------------------------------------
module testbench;
    timeunit 1ns;
    timeprecision 1ps;

    class remap_scoreboard;
        logic [cidr_pkg::ID_W-1:0]  cnt;
        logic [cidr_pkg::ID_W-1:0]  rem;
        logic [cidr_pkg::ID_W-1:0]  cur_offset;
        logic [cidr_pkg::ID_W-1:0]  max_hint;
        logic [cidr_pkg::ID_W-1:0]  key_q[$];
        logic [cidr_pkg::ID_W-1:0]  off_q[$];
        cidr_pkg::t_rsp             pending[$];
        int                         mismatches;

        function new();
            cnt = 64'd1;
            rem = 64'd0;
            cur_offset = 64'd0;
            max_hint = 64'd1;
            mismatches = 0;
        endfunction

        function int find_key(logic [cidr_pkg::ID_W-1:0] k);
            foreach (key_q[i])
                if (key_q[i] == k) return i;
            return -1;
        endfunction

        function void note_request(cidr_pkg::t_req r);
            cidr_pkg::t_rsp            x;
            int                        s;
            logic [cidr_pkg::ID_W-1:0] n;
            logic [cidr_pkg::ID_W-1:0] grown;
            logic [cidr_pkg::ID_W-1:0] applied;
            x = '0;
            x.mapped_id = r.clause_id;
            s = find_key(r.clause_id);
            case (r.func)
                cidr_pkg::FN_HINT: begin
                    if (s >= 0) begin
                        x.mapped_id = r.clause_id + off_q[s];
                        x.entry_found = 1'b1;
                    end
                    if (x.mapped_id > max_hint) max_hint = x.mapped_id;
                end
                cidr_pkg::FN_ASSIGN: begin
                    n = (cnt == 64'd0) ? 64'd1 : cnt;
                    applied = cur_offset + rem;
                    x.entry_found = (s >= 0);
                    x.mapped_id = r.clause_id + applied;
                    if (x.mapped_id <= max_hint) begin
                        grown = 64'd1 + max_hint - r.clause_id;
                        grown = grown + (n - grown % n) % n;
                        applied = grown + rem;
                        x.mapped_id = r.clause_id + applied;
                        cur_offset = grown;
                    end
                    if (s >= 0) begin
                        off_q[s] = applied;
                    end else if (key_q.size() >= cidr_pkg::TABLE_ENTRIES) begin
                        x.table_full = 1'b1;
                    end else begin
                        key_q.push_back(r.clause_id);
                        off_q.push_back(applied);
                    end
                    max_hint = 64'd1;
                end
                cidr_pkg::FN_DELETE: begin
                    if (s >= 0) begin
                        x.mapped_id = r.clause_id + off_q[s];
                        x.entry_found = 1'b1;
                        key_q.delete(s);
                        off_q.delete(s);
                    end
                end
                default: ;
            endcase
            pending.push_back(x);
        endfunction

        function void check_result(cidr_pkg::t_rsp got);
            cidr_pkg::t_rsp want;
            if (pending.size() == 0) begin
                mismatches++;
                if (mismatches <= 10) $display("unexpected result %h", got);
                return;
            end
            want = pending.pop_front();
            if (got.mapped_id !== want.mapped_id || got.entry_found !== want.entry_found
                    || got.table_full !== want.table_full) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("mismatch: want id %h found %b full %b, got id %h found %b full %b",
                             want.mapped_id, want.entry_found, want.table_full,
                             got.mapped_id, got.entry_found, got.table_full);
            end
        endfunction
    endclass

    logic                          i_clk = 1'b0;
    logic                          i_rst_n = 1'b0;
    logic                          start = 1'b0;
    logic                          busy;
    cidr_pkg::t_req                i_req = '0;
    logic                          o_strobe;
    cidr_pkg::t_rsp                o_rsp;
    logic                          i_cfg_we = 1'b0;
    logic [1:0]                    i_cfg_idx = cidr_pkg::CFG_SOLVER_COUNT;
    logic [cidr_pkg::CFG_W-1:0]    i_cfg_wdata = '0;

    remap_scoreboard               sb = new();
    logic [cidr_pkg::ID_W-1:0]     used_ids[$];

    clause_id_offset_remapper dut (.*);

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    always @(posedge i_clk)
        if (i_rst_n && o_strobe) sb.check_result(o_rsp);

    // drop the request lines; call only at an edge where they were not driven
    task automatic idle_bus();
        start <= 1'b0;
        i_req <= '0;
    endtask

    task automatic send_request(logic [1:0] fn, logic [cidr_pkg::ID_W-1:0] id);
        cidr_pkg::t_req r;
        int             gap;
        gap = $urandom_range(0, 5);
        if (gap > 0) begin
            idle_bus();
            repeat (gap) @(posedge i_clk);
        end
        r.func = fn;
        r.clause_id = id;
        start <= 1'b1;
        i_req <= r;
        do @(posedge i_clk); while (busy);
        sb.note_request(r);
    endtask

    task automatic write_reg(logic [1:0] idx, logic [cidr_pkg::CFG_W-1:0] val);
        idle_bus();
        wait (sb.pending.size() == 0);
        repeat (8) @(posedge i_clk);
        i_cfg_we <= 1'b1;
        i_cfg_idx <= idx;
        i_cfg_wdata <= val;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        if (idx == cidr_pkg::CFG_SOLVER_COUNT) sb.cnt = 64'(val);
        else sb.rem = 64'(val[cidr_pkg::REM_W-1:0]);
    endtask

    function automatic logic [cidr_pkg::ID_W-1:0] rand_id();
        case ($urandom_range(0, 3))
            0: return {$urandom, $urandom};
            1: return 64'hFFFF_FFFF_FFFF_FFFF - 64'($urandom_range(0, 64));
            default: return 64'($urandom_range(0, 5000));
        endcase
    endfunction

    task automatic random_phase(int count);
        logic [cidr_pkg::ID_W-1:0] id;
        int                        k;
        repeat (count) begin
            k = $urandom_range(0, 99);
            if (used_ids.size() > 0 && k < 55)
                id = used_ids[$urandom_range(0, used_ids.size() - 1)];
            else
                id = rand_id();
            if (k < 40) begin
                send_request(cidr_pkg::FN_HINT, id);
            end else if (k < 75) begin
                send_request(cidr_pkg::FN_ASSIGN, id);
                used_ids.push_back(id);
            end else if (k < 95) begin
                send_request(cidr_pkg::FN_DELETE, id);
            end else begin
                send_request(cidr_pkg::FN_NOP, id);
            end
        end
    endtask

    initial begin
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;
        // directed: extremes, each function, zero offset, absent delete
        send_request(cidr_pkg::FN_HINT, 64'd0);
        send_request(cidr_pkg::FN_ASSIGN, 64'd0);
        send_request(cidr_pkg::FN_HINT, 64'd0);
        send_request(cidr_pkg::FN_DELETE, 64'd0);
        send_request(cidr_pkg::FN_DELETE, 64'd0);
        send_request(cidr_pkg::FN_HINT, 64'hFFFF_FFFF_FFFF_FFFF);
        send_request(cidr_pkg::FN_ASSIGN, 64'd5);
        send_request(cidr_pkg::FN_ASSIGN, 64'd5);
        send_request(cidr_pkg::FN_HINT, 64'd5);
        send_request(cidr_pkg::FN_ASSIGN, 64'hFFFF_FFFF_FFFF_FFFF);
        send_request(cidr_pkg::FN_NOP, 64'hAAAA_5555_AAAA_5555);
        send_request(cidr_pkg::FN_NOP, 64'h5555_AAAA_5555_AAAA);
        write_reg(cidr_pkg::CFG_SOLVER_COUNT, 11'd7);
        write_reg(cidr_pkg::CFG_SOLVER_REM, 11'd3);
        send_request(cidr_pkg::FN_HINT, 64'd100);
        send_request(cidr_pkg::FN_ASSIGN, 64'd10);
        send_request(cidr_pkg::FN_DELETE, 64'd10);
        write_reg(cidr_pkg::CFG_SOLVER_COUNT, 11'd0);
        write_reg(cidr_pkg::CFG_SOLVER_REM, 11'd1023);
        send_request(cidr_pkg::FN_HINT, 64'h8000_0000_0000_0000);
        send_request(cidr_pkg::FN_ASSIGN, 64'd1);
        random_phase(150);
        write_reg(cidr_pkg::CFG_SOLVER_COUNT, 11'd2047);
        write_reg(cidr_pkg::CFG_SOLVER_REM, 11'd0);
        random_phase(150);
        write_reg(cidr_pkg::CFG_SOLVER_COUNT, 11'd1024);
        write_reg(cidr_pkg::CFG_SOLVER_REM, 11'd1023);
        random_phase(150);
        write_reg(cidr_pkg::CFG_SOLVER_COUNT, 11'd1);
        write_reg(cidr_pkg::CFG_SOLVER_REM, 11'd0);
        random_phase(150);
        idle_bus();
        wait (sb.pending.size() == 0);
        repeat (20) @(posedge i_clk);
        if (sb.mismatches == 0 && sb.pending.size() == 0) begin
            $display("clause_id_offset_remapper regression: pass");
        end else begin
            $display("clause_id_offset_remapper regression: fail");
        end
        $finish;
    end

    // ~650 requests, each with its table scan, plus gaps, with wide margin
    initial begin
        #40ms;
        $display("clause_id_offset_remapper regression: fail");
        $finish;
    end
endmodule

/* files.f */
+incdir+rtl
rtl/cidr_pkg.sv
rtl/cidr_table.sv
rtl/cidr_mod.sv
rtl/clause_id_offset_remapper.sv
tb/sv/testbench.sv
